>>> hdl/sobel_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared types, constants and helpers of the Sobel edge magnitude unit.
// ----------------------------------------------------------------------------
package sobel_pkg;

	localparam int unsigned CfgIdxW = 1;
	localparam logic [CfgIdxW-1:0] REG_FRAME_WIDTH = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_FRAME_HEIGHT = 1'b1;
	localparam int unsigned CfgDataW = 12;
	localparam logic [11:0] WIDTH_RESET = 12'd640;
	localparam logic [11:0] HEIGHT_RESET = 12'd480;
	localparam logic [16:0] MAG_LIMIT = 17'd65280;

	typedef logic [23:0] pixel_t;

	// Window column: top, middle, bottom pixel.
	typedef struct packed {
		pixel_t top;
		pixel_t mid;
		pixel_t bot;
	} column_t;

	// Request passed from the front part to the back part.
	typedef struct packed {
		column_t left;
		column_t center;
		column_t right;
		logic    last;
	} window_req_t;

	// Gradient sum of one channel, range -1020..1020.
	function automatic logic signed [11:0] grad_sum(
		input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
		input logic [7:0] d, input logic [7:0] e, input logic [7:0] f);
		logic signed [11:0] p;
		logic signed [11:0] q;
		begin
			p = $signed({4'd0, a}) + $signed({3'd0, b, 1'b0}) + $signed({4'd0, c});
			q = $signed({4'd0, d}) + $signed({3'd0, e, 1'b0}) + $signed({4'd0, f});
			grad_sum = p - q;
		end
	endfunction

endpackage

>>> hdl/sobel_front.sv
// ----------------------------------------------------------------------------
// Sobel front part
// Accepts pixels and flush ticks, keeps the line buffers and the 3x3 window,
// and issues one window request per result into the queue.
// ----------------------------------------------------------------------------
module sobel_front import sobel_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 2048
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                action,
	input  pixel_t              pix_in,
	output logic                req_valid,
	input  logic                req_ready,
	output window_req_t         req
);
	localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned CW = $clog2(MAX_WIDTH + 1);

	logic [11:0] width_q, height_q;
	logic [CW-1:0] eff_w;
	logic [11:0] eff_h;
	logic [CW-1:0] in_col_q, out_col_q;
	logic [12:0] in_row_q;
	logic [11:0] out_row_q;
	column_t win_c_q, win_r_q;
	pixel_t up_mem [MAX_WIDTH];
	pixel_t mid_mem [MAX_WIDTH];

	// Stage 1 holds an accepted item while the line buffers are read.
	logic          v_s1;
	logic [12:0]   row_s1;
	logic          col0_s1;
	pixel_t        pix_s1, up_s1, mid_s1;
	logic          emit_s1, last_s1;

	logic h_flush, take, adv;
	logic [CW-1:0] col_next;
	logic emit_n, last_n, col0;
	logic [AW-1:0] col_a;
	column_t newcol;

	always_comb begin
		if (width_q == 12'd0) eff_w = CW'(1);
		else if (32'(width_q) > MAX_WIDTH) eff_w = CW'(MAX_WIDTH);
		else eff_w = CW'(width_q);
		eff_h = (height_q == 12'd0) ? 12'd1 : height_q;
	end

	assign h_flush = (in_row_q >= {1'b0, eff_h});
	assign col_a = in_col_q[AW-1:0];
	assign col0 = (in_col_q == '0);
	assign emit_n = col0 ? (in_row_q >= 13'd2) : (in_row_q >= 13'd1);
	assign last_n = emit_n && (out_row_q == eff_h - 12'd1) && (out_col_q == eff_w - CW'(1));
	assign in_ready = !v_s1 || !emit_s1 || req_ready;
	assign take = in_valid && in_ready && !(!h_flush && action);
	assign adv = v_s1 && (!emit_s1 || req_ready);

	always_ff @(posedge clk) begin
		if (take) begin
			mid_s1 <= mid_mem[col_a];
			up_s1 <= up_mem[col_a];
			up_mem[col_a] <= mid_mem[col_a];
			mid_mem[col_a] <= h_flush ? '0 : pix_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pix_s1 <= h_flush ? '0 : pix_in;
			row_s1 <= in_row_q;
			col0_s1 <= col0;
			emit_s1 <= emit_n;
			last_s1 <= last_n;
		end
	end

	always_comb begin
		newcol.top = (row_s1 >= 13'd2) ? up_s1 : '0;
		newcol.mid = (row_s1 >= 13'd1) ? mid_s1 : '0;
		newcol.bot = pix_s1;
	end

	// Result request: a column-zero item closes the previous row's last pixel.
	always_comb begin
		req.last = last_s1;
		if (col0_s1) begin
			req.left = win_c_q;
			req.center = win_r_q;
			req.right = '0;
		end else begin
			req.left = win_c_q;
			req.center = win_r_q;
			req.right = newcol;
		end
	end
	assign req_valid = v_s1 && emit_s1;

	assign col_next = in_col_q + CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			v_s1 <= 1'b0;
			win_c_q <= '0;
			win_r_q <= '0;
		end else if (cfg_we) begin
			if (cfg_idx == REG_FRAME_WIDTH) width_q <= cfg_data;
			if (cfg_idx == REG_FRAME_HEIGHT) height_q <= cfg_data;
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			v_s1 <= 1'b0;
			win_c_q <= '0;
			win_r_q <= '0;
		end else begin
			if (adv) begin
				if (last_s1) begin
					win_c_q <= '0;
					win_r_q <= '0;
				end else begin
					win_c_q <= col0_s1 ? '0 : win_r_q;
					win_r_q <= newcol;
				end
			end
			if (take) v_s1 <= 1'b1;
			else if (adv) v_s1 <= 1'b0;
			if (take) begin
				if (last_n) begin
					in_col_q <= '0;
					in_row_q <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end else begin
					if (col_next >= eff_w) begin
						in_col_q <= '0;
						in_row_q <= in_row_q + 13'd1;
					end else begin
						in_col_q <= col_next;
					end
					if (emit_n) begin
						if (out_col_q + CW'(1) >= eff_w) begin
							out_col_q <= '0;
							out_row_q <= out_row_q + 12'd1;
						end else begin
							out_col_q <= out_col_q + CW'(1);
						end
					end
				end
			end
		end
	end

endmodule

>>> hdl/sobel_queue.sv
// ----------------------------------------------------------------------------
// Sobel request queue
// Two-entry queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module sobel_queue import sobel_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        flush,
	input  logic        wr_valid,
	output logic        wr_ready,
	input  window_req_t wr_data,
	output logic        rd_valid,
	input  logic        rd_ready,
	output window_req_t rd_data
);
	window_req_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else if (flush) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule

>>> hdl/sobel_back.sv
// ----------------------------------------------------------------------------
// Sobel back part
// Gradient sums, squares and rounded square root per channel, pipelined,
// with an output register stage and backpressure.
// ----------------------------------------------------------------------------
module sobel_back import sobel_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        flush,
	input  logic        req_valid,
	output logic        req_ready,
	input  window_req_t req,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] mag_out,
	output logic        last_out
);
	// Stage 1: gradients. Stage 2: squared norm. Stages 3..10: one root bit each.
	localparam int unsigned NS = 11;

	logic [NS-1:0] v_q;
	logic en;
	logic signed [11:0] gx_s1 [3], gy_s1 [3];
	logic [16:0] n_s2 [3];
	logic sat_s2 [3];
	logic [16:0] n_p [3][9];
	logic [7:0]  k_p [3][9];
	logic        sat_p [3][9];
	logic        last_p [NS];

	assign en = !v_q[NS-1] || out_ready;
	assign req_ready = en;
	assign out_valid = v_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (flush) v_q <= '0;
		else if (en) v_q <= {v_q[NS-2:0], req_valid};
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_ch
		localparam int Sh = 16 - 8 * ch;
		logic [16:0] sq;
		logic [21:0] sqx, sqy;
		always_comb begin
			sqx = 22'(unsigned'(22'(gx_s1[ch] * gx_s1[ch])));
			sqy = 22'(unsigned'(22'(gy_s1[ch] * gy_s1[ch])));
		end
		always_ff @(posedge clk) begin
			if (en) begin
				gx_s1[ch] <= grad_sum(req.right.top[Sh+:8], req.right.mid[Sh+:8],
					req.right.bot[Sh+:8], req.left.top[Sh+:8], req.left.mid[Sh+:8],
					req.left.bot[Sh+:8]);
				gy_s1[ch] <= grad_sum(req.left.bot[Sh+:8], req.center.bot[Sh+:8],
					req.right.bot[Sh+:8], req.left.top[Sh+:8], req.center.top[Sh+:8],
					req.right.top[Sh+:8]);
				sat_s2[ch] <= (23'(sqx) + 23'(sqy)) > 23'(MAG_LIMIT);
				n_s2[ch] <= 17'(sqx + sqy);
			end
		end
		assign sq = 17'd0;
		always_comb begin
			n_p[ch][0] = n_s2[ch] | sq;
			k_p[ch][0] = '0;
			sat_p[ch][0] = sat_s2[ch];
		end
		for (genvar b = 0; b < 8; b++) begin : g_bit
			logic [7:0] t;
			logic [16:0] tt;
			always_comb begin
				t = k_p[ch][b] | (8'd128 >> b);
				tt = 17'(16'(t) * 16'(t));
			end
			always_ff @(posedge clk) begin
				if (en) begin
					n_p[ch][b+1] <= n_p[ch][b];
					sat_p[ch][b+1] <= sat_p[ch][b];
					k_p[ch][b+1] <= (tt <= n_p[ch][b]) ? t : k_p[ch][b];
				end
			end
		end
		logic [16:0] kk;
		logic [7:0] rnd;
		always_comb begin
			kk = 17'(16'(k_p[ch][8]) * 16'(k_p[ch][8])) + 17'(k_p[ch][8]);
			rnd = k_p[ch][8] + 8'((n_p[ch][8] > kk) ? 1 : 0);
		end
		logic [7:0] res_q;
		always_ff @(posedge clk) begin
			if (en) res_q <= sat_p[ch][8] ? 8'd255 : rnd;
		end
		assign mag_out[Sh+:8] = res_q;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_p[0] <= req.last;
			for (int i = 1; i < NS; i++) last_p[i] <= last_p[i-1];
		end
	end
	assign last_out = last_p[NS-1];
endmodule

>>> hdl/sobel_edge_magnitude_3x3_unit.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude unit
// Per-channel 3x3 Sobel magnitude of a raster RGB pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on the in channel (valid/ready) in raster order, action low.
// After the last pixel of a frame, flush requests (action high) push out the
// remaining results; a pixel sent during the flush acts as a flush request.
// Results leave on the out channel; frame_end marks the last one of a frame.
// A result appears one row plus one pixel of requests after its pixel. It is
// computed from the request that completes it, once accepted, by the queue
// write, gradients, squared norm, eight square root bit steps and the output
// register, the line buffers being read at the accepting edge.
// The block accepts one request per cycle as long as the receiver takes
// results; a two-entry queue separates the window logic from the arithmetic.
// When the receiver stalls, the pipeline holds and the queue fills, after
// which in_ready drops. Reset or a register write restarts the frame and
// drops results in flight; line buffer contents need no clearing.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_3x3_unit import sobel_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 2048
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                action,
	input  logic [7:0]          red_in,
	input  logic [7:0]          green_in,
	input  logic [7:0]          blue_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          red_out,
	output logic [7:0]          green_out,
	output logic [7:0]          blue_out,
	output logic                frame_end
);
	logic f_valid, f_ready, b_valid, b_ready;
	window_req_t f_req, b_req;
	logic [23:0] mag;

	sobel_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data,
		.in_valid, .in_ready, .action,
		.pix_in({red_in, green_in, blue_in}),
		.req_valid(f_valid), .req_ready(f_ready), .req(f_req)
	);

	sobel_queue u_queue (
		.clk, .arst_n, .flush(cfg_we),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_req),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_req)
	);

	sobel_back u_back (
		.clk, .arst_n, .flush(cfg_we),
		.req_valid(b_valid), .req_ready(b_ready), .req(b_req),
		.out_valid, .out_ready, .mag_out(mag), .last_out(frame_end)
	);

	assign red_out = mag[23:16];
	assign green_out = mag[15:8];
	assign blue_out = mag[7:0];
endmodule

>>> hdl/sobel_checker.sv
// ----------------------------------------------------------------------------
// Sobel port checker
// Port-level assertions for the Sobel edge magnitude unit.
// ----------------------------------------------------------------------------
module sobel_port_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_we,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] red_out,
	input logic       frame_end
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n || cfg_we)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");
	a_red_hold: assert property (@(posedge clk) disable iff (!arst_n || cfg_we)
		out_valid && !out_ready |=> $stable(red_out))
		else $error("result changed while stalled");
	a_end_hold: assert property (@(posedge clk) disable iff (!arst_n || cfg_we)
		out_valid && !out_ready |=> $stable(frame_end))
		else $error("frame end changed while stalled");
	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !out_valid)
		else $error("result survived a register write");
endmodule

bind sobel_edge_magnitude_3x3_unit sobel_port_checker u_sobel_checker (
	.clk, .arst_n, .cfg_we, .out_valid, .out_ready, .red_out, .frame_end
);

>>> tb/sobel_checker.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude checker
// Watches the configuration port and the in and out channels of the Sobel edge
// magnitude unit. It keeps its own copy of the line buffers, the window and
// the frame counters, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module sobel_checker import sobel_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic                action,
	input  logic [7:0]          red_in,
	input  logic [7:0]          green_in,
	input  logic [7:0]          blue_in,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [7:0]          red_out,
	input  logic [7:0]          green_out,
	input  logic [7:0]          blue_out,
	input  logic                frame_end,
	output int                  pending,
	output int                  errors,
	output int                  results_seen
);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} edge_result_t;

	logic [11:0] width_reg;
	logic [11:0] height_reg;
	pixel_t upper_line [0:2047];
	pixel_t middle_line [0:2047];
	pixel_t win [0:8];
	int in_col, in_row, out_col, out_row;
	edge_result_t expected_q [$];

	function automatic int chan(input pixel_t p, input int sh);
		return int'((p >> sh) & 24'hFF);
	endfunction

	function automatic logic [7:0] rounded_norm(input int gx, input int gy);
		int n;
		int k;
		int t;
		begin
			n = gx * gx + gy * gy;
			if (n > 65280) return 8'd255;
			k = 0;
			for (int b = 128; b != 0; b = b >> 1) begin
				t = k | b;
				if (t * t <= n) k = t;
			end
			if (n > k * k + k) k++;
			return k[7:0];
		end
	endfunction

	function automatic logic [7:0] window_edge(input pixel_t l0, input pixel_t l1, input pixel_t l2,
			input pixel_t c0, input pixel_t c2, input pixel_t r0, input pixel_t r1,
			input pixel_t r2, input int sh);
		int gx;
		int gy;
		begin
			gx = (chan(r0, sh) + 2 * chan(r1, sh) + chan(r2, sh))
				- (chan(l0, sh) + 2 * chan(l1, sh) + chan(l2, sh));
			gy = (chan(l2, sh) + 2 * chan(c2, sh) + chan(r2, sh))
				- (chan(l0, sh) + 2 * chan(c0, sh) + chan(r0, sh));
			return rounded_norm(gx, gy);
		end
	endfunction

	task automatic restart_frame();
		for (int i = 0; i < 9; i++) win[i] = '0;
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
	endtask

	task automatic predict_request(input logic flush, input pixel_t data);
		int w;
		int h;
		int r;
		int c;
		pixel_t p;
		pixel_t up;
		pixel_t md;
		edge_result_t res;
		logic emit;
		begin
			w = (width_reg == 0) ? 1 : (width_reg > 2048) ? 2048 : int'(width_reg);
			h = (height_reg == 0) ? 1 : int'(height_reg);
			r = in_row;
			c = in_col;
			emit = 1'b0;
			res = '0;
			if (c >= w) c = w - 1;
			if (r < h) begin
				if (flush) return;
				p = data;
			end else begin
				p = '0;
			end
			up = (r >= 2) ? upper_line[c] : '0;
			md = (r >= 1) ? middle_line[c] : '0;
			upper_line[c] = middle_line[c];
			middle_line[c] = p;
			if (c == 0) begin
				if (r >= 2) begin
					for (int i = 0; i < 3; i++)
						res[24 - 8 * i -: 8] = window_edge(win[3], win[4], win[5], win[6], win[8],
							'0, '0, '0, 16 - 8 * i);
					emit = 1'b1;
				end
				for (int i = 0; i < 6; i++) win[i] = '0;
			end else begin
				for (int i = 0; i < 6; i++) win[i] = win[i + 3];
			end
			win[6] = up;
			win[7] = md;
			win[8] = p;
			if (c != 0 && r >= 1) begin
				for (int i = 0; i < 3; i++)
					res[24 - 8 * i -: 8] = window_edge(win[0], win[1], win[2], win[3], win[5],
						win[6], win[7], win[8], 16 - 8 * i);
				emit = 1'b1;
			end
			if (emit) begin
				res.last = (out_row == h - 1) && (out_col == w - 1);
				expected_q.push_back(res);
				out_col++;
				if (out_col >= w) begin
					out_col = 0;
					out_row++;
				end
			end
			if (emit && res.last) begin
				restart_frame();
			end else begin
				c++;
				if (c >= w) begin
					c = 0;
					r++;
				end
				in_col = c;
				in_row = r;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		edge_result_t exp_res;
		if (!arst_n) begin
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			restart_frame();
			expected_q.delete();
			errors = 0;
			results_seen = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result r=%0d g=%0d b=%0d end=%0b", $time,
						red_out, green_out, blue_out, frame_end);
				end else begin
					exp_res = expected_q.pop_front();
					if (red_out !== exp_res.red) begin
						errors++;
						$display("%0t: red_out expected %0d actual %0d", $time, exp_res.red,
							red_out);
					end
					if (green_out !== exp_res.green) begin
						errors++;
						$display("%0t: green_out expected %0d actual %0d", $time, exp_res.green,
							green_out);
					end
					if (blue_out !== exp_res.blue) begin
						errors++;
						$display("%0t: blue_out expected %0d actual %0d", $time, exp_res.blue,
							blue_out);
					end
					if (frame_end !== exp_res.last) begin
						errors++;
						$display("%0t: frame_end expected %0b actual %0b", $time, exp_res.last,
							frame_end);
					end
				end
			end
			if (cfg_we) begin
				if (cfg_idx == REG_FRAME_WIDTH) width_reg = cfg_data;
				else height_reg = cfg_data;
				restart_frame();
			end
			if (in_valid && in_ready)
				predict_request(action, {red_in, green_in, blue_in});
			pending = expected_q.size();
		end
	end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude testbench
// Drives whole frames of random RGB pixels and flush requests through the
// unit over many frame sizes, with random idling on both channels, and lets
// the checker predict and compare every result.
// ----------------------------------------------------------------------------
module testbench import sobel_pkg::*;;

	localparam int WATCHDOG_LIMIT = 4000;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_idx;
	logic [CfgDataW-1:0] cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic                action;
	logic [7:0]          red_in;
	logic [7:0]          green_in;
	logic [7:0]          blue_in;
	logic                out_valid;
	logic                out_ready;
	logic [7:0]          red_out;
	logic [7:0]          green_out;
	logic [7:0]          blue_out;
	logic                frame_end;
	int                  pending;
	int                  errors;
	int                  results_seen;
	int                  requests_sent;
	int                  frames_sent;
	int                  stall_cycles;
	logic                calm;

	sobel_edge_magnitude_3x3_unit u_top (.*);

	sobel_checker u_checker (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) out_ready <= calm || ($urandom_range(99) >= 16);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_request(input logic flush, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		while (!calm && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= flush;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		requests_sent++;
	endtask

	task automatic write_sizes(input logic [11:0] w, input logic [11:0] h);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= REG_FRAME_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_idx <= REG_FRAME_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] pixel_value();
		int sel;
		begin
			sel = $urandom_range(9);
			if (sel == 0) return 8'd0;
			if (sel == 1) return 8'd255;
			return 8'($urandom);
		end
	endfunction

	task automatic run_frame(input logic [11:0] w_reg, input logic [11:0] h_reg,
			input logic noisy);
		int w;
		int h;
		begin
			w = (w_reg == 0) ? 1 : (w_reg > 2048) ? 2048 : int'(w_reg);
			h = (h_reg == 0) ? 1 : int'(h_reg);
			write_sizes(w_reg, h_reg);
			for (int i = 0; i < w * h; i++) begin
				if (noisy && $urandom_range(19) == 0)
					send_request(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
				send_request(1'b0, pixel_value(), pixel_value(), pixel_value());
			end
			for (int i = 0; i <= w; i++) begin
				if (noisy && $urandom_range(2) == 0)
					send_request(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
				else
					send_request(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
			end
			if (noisy && $urandom_range(3) == 0)
				send_request(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
			frames_sent++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		action = 1'b0;
		red_in = '0;
		green_in = '0;
		blue_in = '0;
		out_ready = 1'b0;
		calm = 1'b0;
		stall_cycles = 0;
		requests_sent = 0;
		frames_sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A checkered 3x3 frame with a flush request while idle and one mid-frame.
		write_sizes(12'd3, 12'd3);
		send_request(1'b1, 8'd255, 8'd255, 8'd255);
		for (int i = 0; i < 9; i++) begin
			if (i == 4) send_request(1'b1, 8'd0, 8'd0, 8'd0);
			send_request(1'b0, i[0] ? 8'd255 : 8'd0, i[0] ? 8'd0 : 8'd255, 8'(i * 31));
		end
		send_request(1'b1, 8'd0, 8'd0, 8'd0);
		send_request(1'b0, 8'd255, 8'd255, 8'd255);
		send_request(1'b1, 8'd0, 8'd0, 8'd0);
		send_request(1'b1, 8'd0, 8'd0, 8'd0);
		send_request(1'b1, 8'd0, 8'd0, 8'd0);
		frames_sent++;

		run_frame(12'd0, 12'd2, 1'b0);
		run_frame(12'd3, 12'd0, 1'b0);
		run_frame(12'd1, 12'd1, 1'b0);

		while (requests_sent < 850) begin
			calm = (frames_sent >= 12 && frames_sent < 22);
			if ($urandom_range(9) == 0)
				run_frame(12'($urandom_range(9, 40)), 12'($urandom_range(1, 4)), 1'b1);
			else
				run_frame(12'($urandom_range(1, 8)), 12'($urandom_range(1, 6)), 1'b1);
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		$display("Sent %0d requests in %0d frames, widths 1 to 40 and heights 1 to 6.",
			requests_sent, frames_sent);
		$display("Checked %0d results against the prediction.", results_seen);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/sobel_pkg.sv
hdl/sobel_front.sv
hdl/sobel_queue.sv
hdl/sobel_back.sv
hdl/sobel_edge_magnitude_3x3_unit.sv
hdl/sobel_checker.sv
tb/sobel_checker.sv
tb/testbench.sv
